// ===== src/cpdc_pkg.sv =====
// ----------------------------------------------------------------------------
// cpdc_pkg: shared definitions for the clamped PID duty controller
// Register map, field widths, fixed-point constants and the structs that
// carry settings and loop history between the top level and the datapath.
// ----------------------------------------------------------------------------
package cpdc_pkg;

  localparam int INTEGRAL_WIDTH_DEF = 16;

  localparam int ADDR_WIDTH  = 5;
  localparam int DATA_WIDTH  = 32;
  localparam int LEVEL_WIDTH = 7;
  localparam int MEAS_WIDTH  = 9;
  localparam int ERR_WIDTH   = 10;
  localparam int GAIN_WIDTH  = 16;
  localparam int FRAC_BITS   = 16;

  // Clamped P and D terms fit in 21 signed bits (limit is 10.0 in Q16).
  localparam int TERM_WIDTH  = 21;
  localparam int TERM_LIMIT  = 10 * 65536;
  localparam int STEP_LIMIT  = 5;
  localparam int STEP_WIDTH  = 4;

  localparam logic [LEVEL_WIDTH-1:0] TARGET_RST = 7'd0;
  localparam logic [GAIN_WIDTH-1:0]  GAIN_P_RST = 16'd13107;
  localparam logic [GAIN_WIDTH-1:0]  GAIN_I_RST = 16'd66;
  localparam logic [GAIN_WIDTH-1:0]  GAIN_D_RST = 16'd60948;
  localparam logic [LEVEL_WIDTH-1:0] IDLE_RST   = 7'd20;
  localparam logic [LEVEL_WIDTH-1:0] MIN_RST    = 7'd20;
  localparam logic [LEVEL_WIDTH-1:0] MAX_RST    = 7'd65;

  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_ENABLE = 3'd1,
    REG_GAIN_P = 3'd2,
    REG_GAIN_I = 3'd3,
    REG_GAIN_D = 3'd4,
    REG_IDLE   = 3'd5,
    REG_MIN    = 3'd6,
    REG_MAX    = 3'd7
  } cpdc_reg_t;

  typedef struct packed {
    logic [LEVEL_WIDTH-1:0] target_level;
    logic [GAIN_WIDTH-1:0]  gain_p;
    logic [GAIN_WIDTH-1:0]  gain_i;
    logic [GAIN_WIDTH-1:0]  gain_d;
    logic [LEVEL_WIDTH-1:0] idle_duty;
    logic [LEVEL_WIDTH-1:0] min_duty;
    logic [LEVEL_WIDTH-1:0] max_duty;
  } cpdc_cfg_t;

  typedef struct packed {
    logic signed [ERR_WIDTH-1:0] previous_error;
    logic [LEVEL_WIDTH-1:0]      previous_duty;
  } cpdc_hist_t;

endpackage

// ===== src/cpdc_law.sv =====
// ----------------------------------------------------------------------------
// cpdc_law: one control step of the PID law
// Combinational: error, clamped P and D terms, conditional saturating
// integral, Q16 sum, truncation toward zero and the duty clamp.
// ----------------------------------------------------------------------------
module cpdc_law #(
  parameter int INTEGRAL_WIDTH = cpdc_pkg::INTEGRAL_WIDTH_DEF
) (
  input  cpdc_pkg::cpdc_cfg_t                          cfg,
  input  logic signed [cpdc_pkg::MEAS_WIDTH-1:0]       measured_level,
  input  cpdc_pkg::cpdc_hist_t                         hist,
  input  logic signed [INTEGRAL_WIDTH-1:0]             integral_sum,
  output logic signed [INTEGRAL_WIDTH-1:0]             integral_next,
  output cpdc_pkg::cpdc_hist_t                         hist_next
);
  import cpdc_pkg::*;

  localparam int IW      = INTEGRAL_WIDTH;
  localparam int PW      = ERR_WIDTH + GAIN_WIDTH + 1;
  localparam int DW      = ERR_WIDTH + GAIN_WIDTH + 2;
  localparam int IPW     = IW + GAIN_WIDTH + 1;
  localparam int SW      = IW + 19;
  localparam int WW      = SW - FRAC_BITS;

  localparam logic signed [PW-1:0] P_HI = PW'(TERM_LIMIT);
  localparam logic signed [PW-1:0] P_LO = -PW'(TERM_LIMIT);
  localparam logic signed [DW-1:0] D_HI = DW'(TERM_LIMIT);
  localparam logic signed [DW-1:0] D_LO = -DW'(TERM_LIMIT);
  localparam logic signed [ERR_WIDTH-1:0] S_HI = ERR_WIDTH'(STEP_LIMIT);
  localparam logic signed [ERR_WIDTH-1:0] S_LO = -ERR_WIDTH'(STEP_LIMIT);
  localparam logic signed [IW-1:0] I_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] I_MIN = {1'b1, {(IW-1){1'b0}}};

  logic signed [ERR_WIDTH-1:0]  err;
  logic signed [ERR_WIDTH:0]    err_diff;
  logic signed [PW-1:0]         p_prod;
  logic signed [DW-1:0]         d_prod;
  logic signed [TERM_WIDTH-1:0] p_term;
  logic signed [TERM_WIDTH-1:0] d_term;
  logic signed [STEP_WIDTH-1:0] step;
  logic signed [IW:0]           integ_wide;
  logic signed [IW-1:0]         integ_sat;
  logic                         integ_on;
  logic signed [IPW-1:0]        i_prod;
  logic signed [SW-1:0]         total;
  logic signed [WW-1:0]         whole;
  logic signed [WW-1:0]         min_ext;
  logic signed [WW-1:0]         max_ext;
  logic signed [WW-1:0]         lo_clamped;
  logic signed [WW-1:0]         duty_wide;

  assign err = $signed({{(ERR_WIDTH-LEVEL_WIDTH){1'b0}}, cfg.target_level})
             - $signed({{(ERR_WIDTH-MEAS_WIDTH){measured_level[MEAS_WIDTH-1]}},
                        measured_level});
  assign err_diff = $signed({err[ERR_WIDTH-1], err})
                  - $signed({hist.previous_error[ERR_WIDTH-1], hist.previous_error});

  assign p_prod = err * $signed({1'b0, cfg.gain_p});
  assign d_prod = err_diff * $signed({1'b0, cfg.gain_d});

  always_comb begin
    if (p_prod > P_HI) begin
      p_term = TERM_WIDTH'(P_HI);
    end else if (p_prod < P_LO) begin
      p_term = TERM_WIDTH'(P_LO);
    end else begin
      p_term = p_prod[TERM_WIDTH-1:0];
    end
    if (d_prod > D_HI) begin
      d_term = TERM_WIDTH'(D_HI);
    end else if (d_prod < D_LO) begin
      d_term = TERM_WIDTH'(D_LO);
    end else begin
      d_term = d_prod[TERM_WIDTH-1:0];
    end
  end

  // The integral only moves while the last duty sat strictly inside the
  // clamp window, which keeps it from winding up against a limit.
  always_comb begin
    if (err > S_HI) begin
      step = STEP_WIDTH'(S_HI);
    end else if (err < S_LO) begin
      step = STEP_WIDTH'(S_LO);
    end else begin
      step = err[STEP_WIDTH-1:0];
    end
    integ_wide = $signed({integral_sum[IW-1], integral_sum})
               + $signed({{(IW+1-STEP_WIDTH){step[STEP_WIDTH-1]}}, step});
    if (integ_wide[IW] != integ_wide[IW-1]) begin
      integ_sat = integ_wide[IW] ? I_MIN : I_MAX;
    end else begin
      integ_sat = integ_wide[IW-1:0];
    end
    integ_on = (hist.previous_duty > cfg.min_duty) && (hist.previous_duty < cfg.max_duty);
    integral_next = integ_on ? integ_sat : integral_sum;
  end

  assign i_prod = integral_next * $signed({1'b0, cfg.gain_i});

  assign total = $signed({{(SW-LEVEL_WIDTH-FRAC_BITS){1'b0}}, cfg.idle_duty,
                          {FRAC_BITS{1'b0}}})
               + $signed({{(SW-TERM_WIDTH){p_term[TERM_WIDTH-1]}}, p_term})
               + $signed({{(SW-TERM_WIDTH){d_term[TERM_WIDTH-1]}}, d_term})
               + $signed({{(SW-IPW){i_prod[IPW-1]}}, i_prod});

  // Arithmetic shift floors; a negative value with a fraction gets one back
  // so that the integer part is truncated toward zero.
  always_comb begin
    whole = total[SW-1:FRAC_BITS];
    if (total[SW-1] && (|total[FRAC_BITS-1:0])) begin
      whole = whole + WW'(1);
    end
    min_ext = $signed({{(WW-LEVEL_WIDTH){1'b0}}, cfg.min_duty});
    max_ext = $signed({{(WW-LEVEL_WIDTH){1'b0}}, cfg.max_duty});
    lo_clamped = (whole < min_ext) ? min_ext : whole;
    duty_wide  = (lo_clamped > max_ext) ? max_ext : lo_clamped;
  end

  assign hist_next.previous_error = err;
  assign hist_next.previous_duty  = duty_wide[LEVEL_WIDTH-1:0];

endmodule

// ===== src/clamped_pid_duty_controller.sv =====
// ----------------------------------------------------------------------------
// clamped_pid_duty_controller: altitude PID loop producing a motor duty
// Valid/ready sample in, valid/ready duty out, APB-style register port.
// ----------------------------------------------------------------------------
// Each measured_level beat runs one step of a PID law against target_level
// and, while enable is set, yields one duty_percent beat; with enable clear
// the sample is consumed, nothing is produced and the loop state is held.
// The error feeds a proportional term and a derivative term, each clamped
// to plus or minus 10 percent, and an integral that adds the error (limited
// to plus or minus 5 per step) only while the previous duty was strictly
// inside the min/max window; the integral saturates instead of wrapping.
// The Q16 sum of idle duty and the three terms is truncated toward zero and
// clamped to [min_duty, max_duty], with the upper bound winning when the
// two bounds cross. The block takes one sample per clock cycle while its
// output is not held: a sample is registered on acceptance, and the whole
// control step is evaluated from that input register and lands in the
// output register. Throughput is one beat per cycle while the output drains
// and is set by the combinational step, as the loop state written by one
// sample is read by the next. A held output beat back-pressures the input
// register, which can still refill while the output is being taken.
// Registers sit at byte address 4*index: target_level, enable, gain_p,
// gain_i, gain_d, idle_duty, min_duty, max_duty. They should be written
// only while no sample is in flight.
// ----------------------------------------------------------------------------
module clamped_pid_duty_controller #(
  parameter int INTEGRAL_WIDTH = cpdc_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [cpdc_pkg::ADDR_WIDTH-1:0]          paddr,
  input  logic [cpdc_pkg::DATA_WIDTH-1:0]          pwdata,
  output logic [cpdc_pkg::DATA_WIDTH-1:0]          prdata,
  output logic                                     pready,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [cpdc_pkg::MEAS_WIDTH-1:0]   measured_level,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [cpdc_pkg::LEVEL_WIDTH-1:0]         duty_percent
);
  import cpdc_pkg::*;

  // Configuration registers.
  cpdc_cfg_t cfg;
  logic      enable;

  // Input register.
  logic                          sample_valid;
  logic signed [MEAS_WIDTH-1:0]  sample;

  // Loop state.
  logic signed [INTEGRAL_WIDTH-1:0] integral_sum;
  logic signed [INTEGRAL_WIDTH-1:0] integral_next;
  cpdc_hist_t                       hist;
  cpdc_hist_t                       hist_next;

  logic      cfg_write;
  cpdc_reg_t reg_sel;
  logic      sample_go;
  logic      step_run;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = cpdc_reg_t'(paddr[4:2]);

  // The registered sample leaves when it produces nothing (disabled) or
  // when the output register is free or being emptied in this cycle.
  assign sample_go = sample_valid && (!enable || !out_valid || out_ready);
  assign step_run  = sample_go && enable;
  assign in_ready  = !sample_valid || sample_go;

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_TARGET: prdata = DATA_WIDTH'(cfg.target_level);
      REG_ENABLE: prdata = DATA_WIDTH'(enable);
      REG_GAIN_P: prdata = DATA_WIDTH'(cfg.gain_p);
      REG_GAIN_I: prdata = DATA_WIDTH'(cfg.gain_i);
      REG_GAIN_D: prdata = DATA_WIDTH'(cfg.gain_d);
      REG_IDLE:   prdata = DATA_WIDTH'(cfg.idle_duty);
      REG_MIN:    prdata = DATA_WIDTH'(cfg.min_duty);
      REG_MAX:    prdata = DATA_WIDTH'(cfg.max_duty);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_level <= TARGET_RST;
      cfg.gain_p       <= GAIN_P_RST;
      cfg.gain_i       <= GAIN_I_RST;
      cfg.gain_d       <= GAIN_D_RST;
      cfg.idle_duty    <= IDLE_RST;
      cfg.min_duty     <= MIN_RST;
      cfg.max_duty     <= MAX_RST;
      enable           <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_TARGET: cfg.target_level <= pwdata[LEVEL_WIDTH-1:0];
        REG_ENABLE: enable           <= pwdata[0];
        REG_GAIN_P: cfg.gain_p       <= pwdata[GAIN_WIDTH-1:0];
        REG_GAIN_I: cfg.gain_i       <= pwdata[GAIN_WIDTH-1:0];
        REG_GAIN_D: cfg.gain_d       <= pwdata[GAIN_WIDTH-1:0];
        REG_IDLE:   cfg.idle_duty    <= pwdata[LEVEL_WIDTH-1:0];
        REG_MIN:    cfg.min_duty     <= pwdata[LEVEL_WIDTH-1:0];
        REG_MAX:    cfg.max_duty     <= pwdata[LEVEL_WIDTH-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample <= measured_level;
    end
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      sample_valid <= 1'b1;
    end else if (sample_go) begin
      sample_valid <= 1'b0;
    end
  end

  cpdc_law #(
    .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
  ) u_law (
    .cfg           (cfg),
    .measured_level(sample),
    .hist          (hist),
    .integral_sum  (integral_sum),
    .integral_next (integral_next),
    .hist_next     (hist_next)
  );

  // Loop state and the result register advance together on each enabled
  // step, so a held duty beat always matches the stored previous duty.
  always_ff @(posedge clk) begin
    if (step_run) begin
      duty_percent <= hist_next.previous_duty;
    end
    if (rst) begin
      integral_sum <= '0;
      hist         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (step_run) begin
        integral_sum <= integral_next;
        hist         <= hist_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid    <= 1'b0;
      end
    end
  end

  // A pending duty beat is the most recent step's duty.
  a_out_matches_history: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty_percent == hist.previous_duty))
    else $error("pending duty differs from stored previous duty");

  // Loop state only moves on an enabled step.
  a_state_held: assert property (@(posedge clk) disable iff (rst)
    !step_run |=> ($stable(integral_sum) && $stable(hist)))
    else $error("loop state changed without an enabled step");

  // A disabled sample never produces a beat.
  a_no_beat_when_disabled: assert property (@(posedge clk) disable iff (rst)
    (sample_go && !enable && !out_valid) |=> !out_valid)
    else $error("duty beat produced while disabled");

  // Nothing is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !sample_valid))
    else $error("beat pending after reset");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the clamped PID duty controller
// Drives measured altitude samples and register writes into the controller
// and checks every duty beat against a pinned value or a cycle-free predictor of the PID law.
// ----------------------------------------------------------------------------
module tb;
  import cpdc_pkg::*;

  localparam int IW             = INTEGRAL_WIDTH_DEF;
  // The duty beat trails its sample through the input and output registers; wait past that.
  localparam int SETTLE_CYCLES  = 4;
  localparam int STALL_LIMIT    = 2000;
  // A short run of maximum-size steps that keeps the integral climbing.
  localparam int WINDUP_SAMPLES = 40;
  localparam int RANDOM_PHASES  = 15;
  localparam int QUIET_PHASES   = 3;

  localparam logic signed [7:0]            PIN_NONE   = -8'sd1;
  localparam logic signed [MEAS_WIDTH-1:0] LEVEL_LOW  = MEAS_WIDTH'(-256);
  localparam logic signed [MEAS_WIDTH-1:0] LEVEL_HIGH = MEAS_WIDTH'(255);

  // Flavors of register settings used by the random phases.
  typedef enum int {
    MIX_TYPICAL,
    MIX_EXTREME,
    MIX_CROSSED,
    MIX_WILD
  } mix_t;

  // One row of the directed plan: either a register write or a sample.
  // A sample row may pin the duty it must produce; PIN_NONE leaves the
  // expectation to the predictor.
  typedef struct packed {
    logic                          is_cfg;
    cpdc_reg_t                     sel;
    logic [DATA_WIDTH-1:0]         value;
    logic signed [MEAS_WIDTH-1:0]  level;
    logic signed [7:0]             pin;
  } plan_row_t;

  localparam int PLAN_ROWS = 32;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // Disabled after reset: the sample is swallowed without a duty beat.
    '{1'b0, REG_TARGET, 32'd0,     9'sd50,    PIN_NONE},
    '{1'b1, REG_ENABLE, 32'd1,     9'sd0,     PIN_NONE},
    // Zero error gives the idle duty; the previous duty is not above the lower
    // bound, so the integral must not move.
    '{1'b0, REG_TARGET, 32'd0,     9'sd0,     8'sd20},
    '{1'b0, REG_TARGET, 32'd0,     9'sd0,     8'sd20},
    // Both sample extremes: P and D saturate in each direction.
    '{1'b0, REG_TARGET, 32'd0,     LEVEL_HIGH, 8'sd20},
    '{1'b0, REG_TARGET, 32'd0,     LEVEL_LOW,  8'sd40},
    '{1'b0, REG_TARGET, 32'd0,     LEVEL_LOW,  8'sd30},
    // Idle duty above the valid range drives the output onto the upper
    // bound, after which integration stops.
    '{1'b1, REG_IDLE,   32'd127,   9'sd0,     PIN_NONE},
    '{1'b0, REG_TARGET, 32'd0,     LEVEL_LOW,  8'sd65},
    '{1'b0, REG_TARGET, 32'd0,     LEVEL_LOW,  8'sd65},
    '{1'b1, REG_GAIN_I, 32'd0,     9'sd0,     PIN_NONE},
    '{1'b1, REG_GAIN_D, 32'd0,     9'sd0,     PIN_NONE},
    '{1'b1, REG_GAIN_P, 32'd65535, 9'sd0,     PIN_NONE},
    '{1'b1, REG_IDLE,   32'd0,     9'sd0,     PIN_NONE},
    '{1'b1, REG_MIN,    32'd0,     9'sd0,     PIN_NONE},
    '{1'b1, REG_MAX,    32'd127,   9'sd0,     PIN_NONE},
    // A negative sum clamps to a zero lower bound.
    '{1'b0, REG_TARGET, 32'd0,     LEVEL_HIGH, 8'sd0},
    // Largest positive error: target above range against the lowest sample.
    '{1'b1, REG_TARGET, 32'd127,   9'sd0,     PIN_NONE},
    '{1'b0, REG_TARGET, 32'd0,     LEVEL_LOW,  8'sd10},
    '{1'b0, REG_TARGET, 32'd0,     9'sd127,   8'sd0},
    // Half gain: 1.5 percent truncates to 1, minus 1.5 truncates toward zero.
    '{1'b1, REG_TARGET, 32'd0,     9'sd0,     PIN_NONE},
    '{1'b1, REG_GAIN_P, 32'd32768, 9'sd0,     PIN_NONE},
    '{1'b0, REG_TARGET, 32'd0,     -9'sd3,    8'sd1},
    '{1'b0, REG_TARGET, 32'd0,     9'sd3,     8'sd0},
    // Crossed bounds: the upper bound wins.
    '{1'b1, REG_MIN,    32'd100,   9'sd0,     PIN_NONE},
    '{1'b1, REG_MAX,    32'd10,    9'sd0,     PIN_NONE},
    '{1'b0, REG_TARGET, 32'd0,     9'sd0,     8'sd10},
    '{1'b0, REG_TARGET, 32'd0,     LEVEL_LOW,  PIN_NONE},
    // Disable in mid-run: state must survive the ignored sample.
    '{1'b1, REG_ENABLE, 32'd0,     9'sd0,     PIN_NONE},
    '{1'b0, REG_TARGET, 32'd0,     9'sd7,     PIN_NONE},
    '{1'b1, REG_ENABLE, 32'd1,     9'sd0,     PIN_NONE},
    '{1'b0, REG_TARGET, 32'd0,     9'sd9,     PIN_NONE}
  };

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [ADDR_WIDTH-1:0]         paddr;
  logic [DATA_WIDTH-1:0]         pwdata;
  logic [DATA_WIDTH-1:0]         prdata;
  logic                          pready;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [MEAS_WIDTH-1:0]  measured_level;
  logic                          out_valid;
  logic                          out_ready;
  logic [LEVEL_WIDTH-1:0]        duty_percent;

  // Shadow copy of the register file and of the loop history.
  cpdc_cfg_t              shadow;
  logic                   ctl_enable;
  longint                 integ_acc;
  longint                 last_err;
  logic [LEVEL_WIDTH-1:0] last_duty;
  bit                     ceiling_seen;

  logic [LEVEL_WIDTH-1:0] duty_due_q[$];
  logic signed [7:0]      level_pin_q[$];

  int  samples_sent;
  int  samples_seen;
  int  duty_checked;
  int  writes_done;
  int  errors;
  int  idle_cycles;
  bit  quiet;
  bit  calm;

  clamped_pid_duty_controller #(
    .INTEGRAL_WIDTH(IW)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .measured_level (measured_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .duty_percent   (duty_percent)
  );

  always #5 clk = ~clk;

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // One control step of the PID law. Returns -1 when the loop is disabled,
  // in which case nothing in the history changes.
  function automatic int predict_duty(logic signed [MEAS_WIDTH-1:0] level);
    longint err, p_term, i_term, d_term, total, duty, lim, i_max, i_min;
    if (!ctl_enable) return -1;
    lim   = longint'(TERM_LIMIT);
    i_max = (longint'(1) << (IW - 1)) - 1;
    i_min = -i_max - 1;
    err    = longint'(shadow.target_level) - longint'(level);
    p_term = clip(err * longint'(shadow.gain_p), -lim, lim);
    // Conditional integration: only while the last duty was strictly
    // inside the output window, so the integral cannot wind up on a clamp.
    if (last_duty > shadow.min_duty && last_duty < shadow.max_duty) begin
      integ_acc = clip(integ_acc + clip(err, -STEP_LIMIT, STEP_LIMIT), i_min, i_max);
      if (integ_acc == i_max) ceiling_seen = 1'b1;
    end
    i_term   = integ_acc * longint'(shadow.gain_i);
    d_term   = clip((err - last_err) * longint'(shadow.gain_d), -lim, lim);
    last_err = err;
    total = longint'(shadow.idle_duty) * 65536 + p_term + i_term + d_term;
    // Integer division truncates toward zero for negative sums as well.
    duty = total / 65536;
    // Lower bound first, upper bound second: crossed bounds give max_duty.
    duty = clip(duty, longint'(shadow.min_duty), longint'(shadow.max_duty));
    last_duty = duty[LEVEL_WIDTH-1:0];
    return int'(duty);
  endfunction

  // Register value with random junk above its width; the block must ignore it.
  function automatic logic [DATA_WIDTH-1:0] noisy(logic [DATA_WIDTH-1:0] v, int w);
    return ($urandom() << w) | v;
  endfunction

  function automatic logic [GAIN_WIDTH-1:0] draw_gain_edge();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return GAIN_WIDTH'($urandom());
    endcase
  endfunction

  function automatic logic [LEVEL_WIDTH-1:0] draw_level_edge();
    case ($urandom_range(0, 3))
      0:       return 7'd0;
      1:       return 7'd100;
      2:       return 7'd127;
      default: return LEVEL_WIDTH'($urandom());
    endcase
  endfunction

  function automatic cpdc_cfg_t draw_settings(mix_t mix);
    cpdc_cfg_t s;
    s.target_level = LEVEL_WIDTH'($urandom_range(20, 80));
    s.gain_p       = GAIN_WIDTH'($urandom_range(0, 30000));
    s.gain_i       = GAIN_WIDTH'($urandom_range(0, 2000));
    s.gain_d       = GAIN_WIDTH'($urandom());
    s.idle_duty    = LEVEL_WIDTH'($urandom_range(10, 60));
    s.min_duty     = LEVEL_WIDTH'($urandom_range(0, 40));
    s.max_duty     = LEVEL_WIDTH'($urandom_range(50, 100));
    case (mix)
      MIX_EXTREME: begin
        s.target_level = draw_level_edge();
        s.gain_p       = draw_gain_edge();
        s.gain_i       = draw_gain_edge();
        s.gain_d       = draw_gain_edge();
        s.idle_duty    = draw_level_edge();
        s.min_duty     = draw_level_edge();
        s.max_duty     = draw_level_edge();
      end
      MIX_CROSSED: begin
        s.min_duty = LEVEL_WIDTH'($urandom_range(51, 127));
        s.max_duty = LEVEL_WIDTH'($urandom_range(0, 50));
      end
      MIX_WILD: s = cpdc_cfg_t'($bits(cpdc_cfg_t)'({$urandom(), $urandom(), $urandom()}));
      default: ;
    endcase
    return s;
  endfunction

  // Mostly samples near the target so the loop settles inside its window
  // and integrates; the rest spans the whole signed sample range.
  function automatic logic signed [MEAS_WIDTH-1:0] draw_level();
    int v;
    if ($urandom_range(0, 9) < 8) begin
      v = int'(shadow.target_level) + int'($urandom_range(0, 40)) - 20;
      v = int'(clip(v, longint'(LEVEL_LOW), longint'(LEVEL_HIGH)));
      return v[MEAS_WIDTH-1:0];
    end
    return MEAS_WIDTH'($urandom_range(0, 511));
  endfunction

  // Setup cycle, then access cycle; the register takes the value at the
  // edge where the access completes. The bus then goes idle before the next
  // transfer, which never has to drop and raise psel in the same step.
  task automatic reg_write(cpdc_reg_t sel, logic [DATA_WIDTH-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (sel)
      REG_TARGET: shadow.target_level = data[LEVEL_WIDTH-1:0];
      REG_ENABLE: ctl_enable          = data[0];
      REG_GAIN_P: shadow.gain_p       = data[GAIN_WIDTH-1:0];
      REG_GAIN_I: shadow.gain_i       = data[GAIN_WIDTH-1:0];
      REG_GAIN_D: shadow.gain_d       = data[GAIN_WIDTH-1:0];
      REG_IDLE:   shadow.idle_duty    = data[LEVEL_WIDTH-1:0];
      REG_MIN:    shadow.min_duty     = data[LEVEL_WIDTH-1:0];
      REG_MAX:    shadow.max_duty     = data[LEVEL_WIDTH-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  task automatic load_settings(cpdc_cfg_t s, logic en);
    reg_write(REG_TARGET, noisy(DATA_WIDTH'(s.target_level), LEVEL_WIDTH));
    reg_write(REG_GAIN_P, noisy(DATA_WIDTH'(s.gain_p), GAIN_WIDTH));
    reg_write(REG_GAIN_I, noisy(DATA_WIDTH'(s.gain_i), GAIN_WIDTH));
    reg_write(REG_GAIN_D, noisy(DATA_WIDTH'(s.gain_d), GAIN_WIDTH));
    reg_write(REG_IDLE,   noisy(DATA_WIDTH'(s.idle_duty), LEVEL_WIDTH));
    reg_write(REG_MIN,    noisy(DATA_WIDTH'(s.min_duty), LEVEL_WIDTH));
    reg_write(REG_MAX,    noisy(DATA_WIDTH'(s.max_duty), LEVEL_WIDTH));
    reg_write(REG_ENABLE, noisy(DATA_WIDTH'(en), 1));
  endtask

  // Presents one sample beat and returns at the edge that accepts it, with
  // in_valid still high so a back-to-back beat needs no second assignment.
  task automatic send_level(logic signed [MEAS_WIDTH-1:0] level, logic signed [7:0] pin);
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    level_pin_q.push_back(pin);
    in_valid       <= 1'b1;
    measured_level <= level;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  // Registers may only change with nothing in flight. A disabled sample
  // leaves no expectation behind, so after the queue drains the block is
  // given its pipeline depth plus margin before the bus is touched.
  task automatic settle();
    in_valid <= 1'b0;
    while (samples_seen != samples_sent || duty_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sample and duty beats are both taken on the same edge the block sees
  // them, so the prediction for a sample is queued before its duty can be
  // compared even if the two were to share an edge.
  always @(posedge clk) begin : scoreboard
    int                     want;
    logic signed [7:0]      pin;
    logic [LEVEL_WIDTH-1:0] due;
    if (!rst && in_valid && in_ready) begin
      want = predict_duty(measured_level);
      pin  = level_pin_q.pop_front();
      samples_seen++;
      if (want >= 0) duty_due_q.push_back(pin != PIN_NONE ? pin[LEVEL_WIDTH-1:0]
                                                          : LEVEL_WIDTH'(want));
    end
    if (!rst && out_valid && out_ready) begin
      if (duty_due_q.size() == 0) begin
        errors++;
        if (errors < 50) $display("%0t: unexpected duty beat, expected none, got %0d",
                                  $time, duty_percent);
      end else begin
        due = duty_due_q.pop_front();
        duty_checked++;
        if (duty_percent !== due) begin
          errors++;
          if (errors < 50) $display("%0t: duty_percent expected %0d, got %0d",
                                    $time, due, duty_percent);
        end
      end
    end
  end

  // Watchdog: any beat on either channel or any register write counts as
  // progress; a long silence means the block has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL clamped_pid_duty_controller");
      $finish;
    end
  end

  // Receiver pacing: ready runs of random length broken by stall bursts,
  // with no stalls at all once the quiet tail of the run begins.
  initial begin : sink_pacing
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int        n;
    cpdc_cfg_t s;
    logic      en;
    mix_t      mix;

    rst            <= 1'b1;
    in_valid       <= 1'b0;
    measured_level <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    shadow     = '{TARGET_RST, GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, IDLE_RST, MIN_RST, MAX_RST};
    ctl_enable = 1'b0;
    integ_acc  = 0;
    last_err   = 0;
    last_duty  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed plan: register rows wait for the block to go idle first.
    for (int k = 0; k < PLAN_ROWS; k++) begin
      if (PLAN[k].is_cfg) begin
        settle();
        reg_write(PLAN[k].sel, PLAN[k].value);
      end else begin
        send_level(PLAN[k].level, PLAN[k].pin);
      end
    end

    // Wind-up stretch: all gains zero hold the duty at idle, strictly inside
    // a wide window, while every error is at least the step limit. The
    // integral climbs by the full step on each beat.
    settle();
    load_settings('{7'd100, 16'd0, 16'd0, 16'd0, 7'd50, 7'd0, 7'd100}, 1'b1);
    calm = ($urandom_range(0, 1) == 0);
    repeat (WINDUP_SAMPLES)
      send_level(MEAS_WIDTH'(int'($urandom_range(0, 351)) - 256), PIN_NONE);

    // Random phases. The first two are the all-ones and all-zero settings,
    // the rest mix typical, extreme, crossed-bound and fully random ones.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      quiet = (ph >= RANDOM_PHASES - QUIET_PHASES);
      calm  = ($urandom_range(0, 3) == 0);
      en    = 1'b1;
      if (ph == 0) begin
        s = '1;
      end else if (ph == 1) begin
        s = '0;
      end else begin
        mix = mix_t'($urandom_range(0, 3));
        s   = draw_settings(mix);
        en  = ($urandom_range(0, 5) != 0);
      end
      load_settings(s, en);
      n = $urandom_range(60, 140);
      repeat (n) send_level(draw_level(), PIN_NONE);
    end

    settle();
    $display("Checked %0d duty beats from %0d samples over %0d register writes,",
             duty_checked, samples_sent, writes_done);
    $display("with crossed bounds, disabled phases and the integral %s its upper limit.",
             ceiling_seen ? "driven to" : "never reaching");
    if (errors == 0) begin
      $display("PASS clamped_pid_duty_controller");
    end else begin
      $display("FAIL clamped_pid_duty_controller");
    end
    $finish;
  end

endmodule
